FILE: rtl/core/sis_pkg.sv
// Package for the sorted insertion stack: field widths, operation codes,
// default sizes and the memory control struct. No dependencies.
package sis_pkg;

  localparam int unsigned KEY_W       = 32;
  localparam int unsigned PAY_PORT_W  = 32;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned OP_W        = 2;

  localparam int unsigned DEPTH_DEF         = 16;
  localparam int unsigned PAYLOAD_WIDTH_DEF = 32;

  localparam logic [OP_W-1:0] OP_SORTED_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_PLAIN_PUSH  = 2'd1;
  localparam logic [OP_W-1:0] OP_POP         = 2'd2;
  localparam logic [OP_W-1:0] OP_PEEK        = 2'd3;

  // Write and read enables from the sequencer to the entry store.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } sis_mem_ctl_t;

endpackage

FILE: rtl/core/sis_store.sv
// Entry store of the sorted insertion stack: key and payload memory with
// one write port and one registered read port. Depends on sis_pkg.
module sis_store
  import sis_pkg::*;
#(
  parameter int unsigned DEPTH         = DEPTH_DEF,
  parameter int unsigned PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF,
  localparam int unsigned AW           = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  sis_mem_ctl_t             mem_ctl,
  input  logic [AW-1:0]            wr_addr,
  input  logic signed [KEY_W-1:0]  wr_key,
  input  logic [PAYLOAD_WIDTH-1:0] wr_pay,
  input  logic [AW-1:0]            rd_addr,
  output logic signed [KEY_W-1:0]  rd_key,
  output logic [PAYLOAD_WIDTH-1:0] rd_pay
);

  logic signed [KEY_W-1:0]  key_mem [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] pay_mem [DEPTH];
  logic signed [KEY_W-1:0]  rd_key_r;
  logic [PAYLOAD_WIDTH-1:0] rd_pay_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      key_mem[wr_addr] <= wr_key;
      pay_mem[wr_addr] <= wr_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rd_key_r <= key_mem[rd_addr];
      rd_pay_r <= pay_mem[rd_addr];
    end
  end

  assign rd_key = rd_key_r;
  assign rd_pay = rd_pay_r;

endmodule

FILE: rtl/core/sis_seq.sv
// Sequencer of the sorted insertion stack: request handshake, fill count,
// shared key comparator for the insert scan, result register. Depends on sis_pkg.
module sis_seq
  import sis_pkg::*;
#(
  parameter int unsigned DEPTH         = DEPTH_DEF,
  parameter int unsigned PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF,
  localparam int unsigned AW           = $clog2(DEPTH),
  localparam int unsigned CNT_W        = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          in_operation,
  input  logic signed [KEY_W-1:0]  in_key,
  input  logic [PAY_PORT_W-1:0]    in_payload,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [KEY_W-1:0]  out_top_key,
  output logic [PAY_PORT_W-1:0]    out_top_payload,
  output logic [COUNT_W-1:0]       out_entry_count,
  output logic                     out_is_empty,
  output logic                     out_error,
  output sis_mem_ctl_t             mem_ctl,
  output logic [AW-1:0]            wr_addr,
  output logic signed [KEY_W-1:0]  wr_key,
  output logic [PAYLOAD_WIDTH-1:0] wr_pay,
  output logic [AW-1:0]            rd_addr,
  input  logic signed [KEY_W-1:0]  rd_key,
  input  logic [PAYLOAD_WIDTH-1:0] rd_pay
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN_RD  = 3'd1;
  localparam logic [2:0] S_SCAN_CMP = 3'd2;
  localparam logic [2:0] S_PLACE    = 3'd3;
  localparam logic [2:0] S_TOP_RD   = 3'd4;
  localparam logic [2:0] S_TOP_CAP  = 3'd5;
  localparam logic [2:0] S_EMIT     = 3'd6;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);
  localparam logic [AW-1:0]    ONE_POS  = AW'(1);

  logic [2:0]               state_r, state_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic [AW-1:0]            pos_r, pos_nxt;
  logic [OP_W-1:0]          op_r;
  logic signed [KEY_W-1:0]  key_r;
  logic [PAYLOAD_WIDTH-1:0] pay_r;
  logic                     err_r;
  logic signed [KEY_W-1:0]  res_key_r;
  logic [PAYLOAD_WIDTH-1:0] res_pay_r;

  logic                     out_valid_r;
  logic signed [KEY_W-1:0]  out_key_r;
  logic [PAY_PORT_W-1:0]    out_pay_r;
  logic [COUNT_W-1:0]       out_count_r;
  logic                     out_empty_r;
  logic                     out_err_r;

  logic                     accept;
  logic                     is_push;
  logic                     key_gt;
  logic                     out_free;
  logic [CNT_W-1:0]         fill_m1;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_push  = (in_operation == OP_SORTED_PUSH) || (in_operation == OP_PLAIN_PUSH);
  assign key_gt   = (key_r > rd_key);
  assign out_free = !out_valid_r || !out_stall;
  assign fill_m1  = fill_r - ONE_CNT;

  // Memory requests: scan reads walk down from the top, shifts write one up.
  always_comb begin
    mem_ctl.rd_en = (state_r == S_SCAN_RD) || (state_r == S_TOP_RD);
    mem_ctl.wr_en = ((state_r == S_SCAN_CMP) && key_gt) || (state_r == S_PLACE);
    rd_addr       = (state_r == S_SCAN_RD) ? (pos_r - ONE_POS) : fill_m1[AW-1:0];
    wr_addr       = pos_r;
    wr_key        = (state_r == S_PLACE) ? key_r : rd_key;
    wr_pay        = (state_r == S_PLACE) ? pay_r : rd_pay;
  end

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    pos_nxt   = pos_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (is_push) begin
            pos_nxt = fill_r[AW-1:0];
            if (fill_r == FULL_CNT) begin
              state_nxt = S_TOP_RD;
            end else if ((in_operation == OP_SORTED_PUSH) && (fill_r != '0)) begin
              state_nxt = S_SCAN_RD;
            end else begin
              state_nxt = S_PLACE;
            end
          end else if (fill_r == '0) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_TOP_RD;
          end
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (key_gt) begin
          // shift this entry up one slot and keep scanning down
          pos_nxt   = pos_r - ONE_POS;
          state_nxt = (pos_r == ONE_POS) ? S_PLACE : S_SCAN_RD;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        fill_nxt  = fill_r + ONE_CNT;
        state_nxt = S_TOP_RD;
      end
      S_TOP_RD: state_nxt = S_TOP_CAP;
      S_TOP_CAP: begin
        if (op_r == OP_POP) begin
          fill_nxt = fill_m1;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  // Request capture and result staging.
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (accept) begin
      op_r      <= in_operation;
      key_r     <= in_key;
      pay_r     <= PAYLOAD_WIDTH'(in_payload);
      err_r     <= is_push ? (fill_r == FULL_CNT) : (fill_r == '0);
      res_key_r <= '0;
      res_pay_r <= '0;
    end else if (state_r == S_TOP_CAP) begin
      res_key_r <= rd_key;
      res_pay_r <= rd_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_EMIT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_EMIT) && out_free) begin
      out_key_r   <= res_key_r;
      out_pay_r   <= PAY_PORT_W'(res_pay_r);
      out_count_r <= COUNT_W'(fill_r);
      out_empty_r <= (fill_r == '0);
      out_err_r   <= err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_top_key     = out_key_r;
  assign out_top_payload = out_pay_r;
  assign out_entry_count = out_count_r;
  assign out_is_empty    = out_empty_r;
  assign out_error       = out_err_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("fill count beyond depth");

  a_scan_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_RD || state_r == S_SCAN_CMP) |-> (pos_r != '0))
    else $error("insert scan below bottom entry");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("request accepted without starting work");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EMIT))
    else $error("result raised outside emit");

  a_place_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PLACE) |-> (fill_r != FULL_CNT))
    else $error("entry placed into full stack");

endmodule

FILE: rtl/core/sorted_insertion_stack_unit.sv
// Top level of the sorted insertion stack: ties the sequencer to the entry
// store. Depends on sis_pkg, sis_seq and sis_store.
//
//  channel   direction  handshake            payload
//  in_       request    in_valid / in_stall  in_operation, in_key, in_payload
//  out_      result     out_valid/out_stall  out_top_key, out_top_payload,
//                                            out_entry_count, out_is_empty,
//                                            out_error
//
// Each request runs alone through one sequencer; the next is taken only when
// the previous has been handed to the result register. Pop and peek read and
// capture the top, then emit; plain push places the entry and then reads the
// top; sorted push first scans down from the top over at most the fill level
// of entries, with one read and one compare per step on the single memory
// read port. A push into a full stack skips the scan and the write. An error
// on empty pop or peek goes straight to the emit step.
// Reset (rst_n low, synchronous) empties the stack; entry memory is not
// cleared, since only entries below the fill level are ever read.
// A stalled result holds in the output register; a finished request waits
// in the emit step while that register is still occupied.
module sorted_insertion_stack_unit
  import sis_pkg::*;
#(
  parameter int unsigned DEPTH         = DEPTH_DEF,
  parameter int unsigned PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_operation,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic [PAY_PORT_W-1:0]   in_payload,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [KEY_W-1:0] out_top_key,
  output logic [PAY_PORT_W-1:0]   out_top_payload,
  output logic [COUNT_W-1:0]      out_entry_count,
  output logic                    out_is_empty,
  output logic                    out_error
);

  localparam int unsigned AW = $clog2(DEPTH);

  // Memory request path between sequencer and store.
  sis_mem_ctl_t             mem_ctl;
  logic [AW-1:0]            wr_addr;
  logic signed [KEY_W-1:0]  wr_key;
  logic [PAYLOAD_WIDTH-1:0] wr_pay;
  logic [AW-1:0]            rd_addr;
  logic signed [KEY_W-1:0]  rd_key;
  logic [PAYLOAD_WIDTH-1:0] rd_pay;

  // Sequencer: accepts requests, walks the insert scan, stages results.
  sis_seq #(
    .DEPTH         (DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_top_key     (out_top_key),
    .out_top_payload (out_top_payload),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_error       (out_error),
    .mem_ctl         (mem_ctl),
    .wr_addr         (wr_addr),
    .wr_key          (wr_key),
    .wr_pay          (wr_pay),
    .rd_addr         (rd_addr),
    .rd_key          (rd_key),
    .rd_pay          (rd_pay)
  );

  // Entry store: index 0 is the bottom of the stack.
  sis_store #(
    .DEPTH         (DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_store (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .wr_addr (wr_addr),
    .wr_key  (wr_key),
    .wr_pay  (wr_pay),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_pay  (rd_pay)
  );

endmodule

FILE: tb/sorted_insertion_stack_unit_tb.sv
// Testbench for sorted_insertion_stack_unit: drives requests, keeps a shadow
// stack to predict each result and checks the results in order.
// Depends on sis_pkg and the sorted_insertion_stack_unit RTL.
`timescale 1ns / 1ps

module sorted_insertion_stack_unit_tb;
  import sis_pkg::*;

  localparam int unsigned STACK_DEPTH = DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 64;

  // One result as the block reports it.
  typedef struct packed {
    logic signed [KEY_W-1:0] top_key;
    logic [PAY_PORT_W-1:0]   top_payload;
    logic [COUNT_W-1:0]      entry_count;
    logic                    is_empty;
    logic                    error;
  } stack_view_t;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [OP_W-1:0]         in_operation;
  logic signed [KEY_W-1:0] in_key;
  logic [PAY_PORT_W-1:0]   in_payload;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [KEY_W-1:0] out_top_key;
  logic [PAY_PORT_W-1:0]   out_top_payload;
  logic [COUNT_W-1:0]      out_entry_count;
  logic                    out_is_empty;
  logic                    out_error;

  // Shadow copy of the stack contents; index 0 is the bottom.
  logic signed [KEY_W-1:0] shadow_keys [STACK_DEPTH];
  logic [PAY_PORT_W-1:0]   shadow_tags [STACK_DEPTH];
  int unsigned             shadow_fill;

  // Results still owed by the block, oldest first.
  stack_view_t pending_tops[$];

  bit          idle_on;
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned op_counts [4];
  int unsigned error_results;
  int unsigned full_hits;

  sorted_insertion_stack_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_top_key     (out_top_key),
    .out_top_payload (out_top_payload),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_error       (out_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: end the run with a failure if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_tops.size());
      $display("sorted_insertion_stack_unit_tb failed");
      $finish;
    end
  end

  // Apply one request to the shadow stack and return the result it must
  // produce. Sorted push walks down from the top past every smaller key, so
  // the new entry lands directly above the first key that is >= it.
  task automatic apply_to_shadow(input logic [OP_W-1:0] op,
                                 input logic signed [KEY_W-1:0] key,
                                 input logic [PAY_PORT_W-1:0] tag,
                                 output stack_view_t view);
    int unsigned slot;
    int unsigned i;
    view = '0;
    case (op)
      OP_SORTED_PUSH, OP_PLAIN_PUSH: begin
        if (shadow_fill >= STACK_DEPTH) begin
          // Full: drop the entry, report the unchanged top.
          view.error = 1'b1;
          full_hits++;
        end else begin
          slot = shadow_fill;
          if (op == OP_SORTED_PUSH) begin
            while (slot > 0 && key > shadow_keys[slot-1]) slot--;
          end
          for (i = shadow_fill; i > slot; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_tags[i] = shadow_tags[i-1];
          end
          shadow_keys[slot] = key;
          shadow_tags[slot] = tag;
          shadow_fill++;
        end
        view.top_key     = shadow_keys[shadow_fill-1];
        view.top_payload = shadow_tags[shadow_fill-1];
      end
      default: begin
        if (shadow_fill == 0) begin
          // Pop or peek on empty: flag it, report zeros, change nothing.
          view.error = 1'b1;
        end else begin
          view.top_key     = shadow_keys[shadow_fill-1];
          view.top_payload = shadow_tags[shadow_fill-1];
          if (op == OP_POP) shadow_fill--;
        end
      end
    endcase
    view.entry_count = shadow_fill[COUNT_W-1:0];
    view.is_empty    = (shadow_fill == 0);
  endtask

  // Offer one request and hold it until the block takes it; the expected
  // result is queued at the accepting edge.
  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic signed [KEY_W-1:0] key,
                              input logic [PAY_PORT_W-1:0] tag);
    stack_view_t view;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key       <= key;
    in_payload   <= tag;
    do @(posedge clk); while (in_stall);
    apply_to_shadow(op, key, tag, view);
    pending_tops.push_back(view);
    op_counts[op]++;
  endtask

  // Keys: extremes, a narrow band that makes equal keys common, or anything.
  function automatic logic signed [KEY_W-1:0] pick_key();
    logic signed [KEY_W-1:0] k;
    case ($urandom_range(0, 9))
      0: k = 32'sh8000_0000;
      1: k = 32'sh7FFF_FFFF;
      2, 3, 4, 5: begin
        k = $urandom_range(0, 7);
        k = k - 4;
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  function automatic logic [PAY_PORT_W-1:0] pick_tag();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Lean the operation mix toward filling or draining so both full and
  // empty get hit often.
  function automatic logic [OP_W-1:0] pick_op(traffic_mode_t mode);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    case (mode)
      MODE_FILL:  return (roll < 6) ? OP_SORTED_PUSH : (roll < 8) ? OP_PLAIN_PUSH :
                         (roll < 9) ? OP_POP : OP_PEEK;
      MODE_DRAIN: return (roll < 1) ? OP_SORTED_PUSH : (roll < 2) ? OP_PLAIN_PUSH :
                         (roll < 8) ? OP_POP : OP_PEEK;
      default:    return OP_W'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Result stall: random bursts while idling is on.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare every accepted result against the oldest expectation.
  initial begin
    stack_view_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_tops.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual key %h payload %h",
                   $time, out_top_key, out_top_payload);
          mismatches++;
        end else begin
          want = pending_tops.pop_front();
          check_field("top_key", 32'(want.top_key), 32'(out_top_key));
          check_field("top_payload", 32'(want.top_payload), 32'(out_top_payload));
          check_field("entry_count", 32'(want.entry_count), 32'(out_entry_count));
          check_field("is_empty", 32'(want.is_empty), 32'(out_is_empty));
          check_field("error", 32'(want.error), 32'(out_error));
          results_checked++;
          if (want.error) error_results++;
        end
      end
    end
  end

  // Pop and peek on an empty stack must flag an error and report zeros.
  task automatic test_empty_stack();
    send_request(OP_POP, 32'sd0, 32'h0);
    send_request(OP_PEEK, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Key extremes, equal keys (newest goes above), plain push over a sorted
  // stack, then one peek and one pop.
  task automatic test_key_order();
    send_request(OP_SORTED_PUSH, 32'sh8000_0000, 32'h0000_0000);
    send_request(OP_SORTED_PUSH, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_SORTED_PUSH, 32'sd0, 32'hA5A5_A5A5);
    send_request(OP_SORTED_PUSH, 32'sd0, 32'h5A5A_5A5A);
    send_request(OP_SORTED_PUSH, -32'sd1, 32'h1234_5678);
    send_request(OP_PLAIN_PUSH, 32'sh7FFF_FFFF, 32'h8765_4321);
    send_request(OP_PEEK, 32'sd0, 32'h0);
    send_request(OP_POP, 32'sd0, 32'h0);
  endtask

  // Top the stack up to full, then push once of each kind into a full stack.
  task automatic test_overflow();
    while (shadow_fill < STACK_DEPTH) send_request(OP_SORTED_PUSH, pick_key(), pick_tag());
    send_request(OP_SORTED_PUSH, 32'sh8000_0000, 32'hDEAD_BEEF);
    send_request(OP_PLAIN_PUSH, 32'sh7FFF_FFFF, 32'hCAFE_F00D);
  endtask

  // Bursts of fill, drain or mixed traffic, with idling switched per burst.
  task automatic test_random_traffic(int unsigned count);
    traffic_mode_t mode;
    int unsigned   burst;
    int unsigned   sent;
    sent = 0;
    while (sent < count) begin
      mode    = traffic_mode_t'($urandom_range(0, 2));
      burst   = $urandom_range(10, 40);
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (burst) begin
        send_request(pick_op(mode), pick_key(), pick_tag());
        sent++;
      end
    end
  endtask

  // Closing stretch: no idling on either side.
  task automatic test_back_to_back(int unsigned count);
    idle_on = 1'b0;
    repeat (count) send_request(pick_op(MODE_MIXED), pick_key(), pick_tag());
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= OP_PEEK;
    in_key       <= '0;
    in_payload   <= '0;
    idle_on      = 1'b1;
    cycle_count  = 0;
    mismatches   = 0;
    results_checked = 0;
    error_results = 0;
    full_hits    = 0;
    shadow_fill  = 0;
    foreach (op_counts[i]) op_counts[i] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_stack();
    test_key_order();
    test_overflow();
    test_random_traffic(1200);
    test_back_to_back(200);

    // Release the input, let every owed result arrive, then watch for strays.
    in_valid <= 1'b0;
    while (pending_tops.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d sorted push, %0d plain push, %0d pop, %0d peek",
             op_counts[OP_SORTED_PUSH] + op_counts[OP_PLAIN_PUSH] + op_counts[OP_POP] +
             op_counts[OP_PEEK], op_counts[OP_SORTED_PUSH], op_counts[OP_PLAIN_PUSH],
             op_counts[OP_POP], op_counts[OP_PEEK]);
    $display("checked %0d results, %0d with error set, %0d pushes into a full stack",
             results_checked, error_results, full_hits);
    if (mismatches == 0) begin
      $display("sorted_insertion_stack_unit_tb passed");
    end else begin
      $display("sorted_insertion_stack_unit_tb failed");
    end
    $finish;
  end

endmodule
